[rtl/rmq_pkg.sv]
// ============================================================================
// rmq_pkg
// Shared item types and constants for the rotation matrix to quaternion core.
// ============================================================================
`default_nettype none

package rmq_pkg;

    localparam int DATA_W = 16;

    // chosen component codes
    localparam logic [1:0] IDX_X = 2'd0;
    localparam logic [1:0] IDX_Y = 2'd1;
    localparam logic [1:0] IDX_Z = 2'd2;
    localparam logic [1:0] IDX_W = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] m00;
        logic signed [DATA_W-1:0] m01;
        logic signed [DATA_W-1:0] m02;
        logic signed [DATA_W-1:0] m10;
        logic signed [DATA_W-1:0] m11;
        logic signed [DATA_W-1:0] m12;
        logic signed [DATA_W-1:0] m20;
        logic signed [DATA_W-1:0] m21;
        logic signed [DATA_W-1:0] m22;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] qx;
        logic signed [DATA_W-1:0] qy;
        logic signed [DATA_W-1:0] qz;
        logic signed [DATA_W-1:0] qw;
        logic [1:0]               largest_index;
        logic                     degenerate;
    } t_out;

endpackage

`default_nettype wire

[rtl/rmq_sqrt_cell.sv]
// ============================================================================
// rmq_sqrt_cell
// One digit step of a floor square root: takes two radicand bits, yields one
// root bit.
// ============================================================================
`default_nettype none

module rmq_sqrt_cell #(
    parameter int RW = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire logic [2*RW-1:0] i_rad,
    input  wire logic [RW:0]     i_rem,
    input  wire logic [RW-1:0]   i_root,
    output logic      [2*RW-1:0] o_rad,
    output logic      [RW:0]     o_rem,
    output logic      [RW-1:0]   o_root
);

    logic [RW+2:0] w_trial_rem;
    logic [RW+2:0] w_trial;
    logic          w_ge;

    assign w_trial_rem = {i_rem, i_rad[2*RW-1 -: 2]};
    assign w_trial     = {1'b0, i_root, 2'b01};
    assign w_ge        = (w_trial_rem >= w_trial);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rad  <= {i_rad[2*RW-3:0], 2'b00};
            o_rem  <= w_ge ? (RW+1)'(w_trial_rem - w_trial) : (RW+1)'(w_trial_rem);
            o_root <= {i_root[RW-2:0], w_ge};
        end
    end

endmodule

`default_nettype wire

[rtl/rmq_div_cell.sv]
// ============================================================================
// rmq_div_cell
// One restoring division step: shifts in one numerator bit, emits one
// quotient bit.
// ============================================================================
`default_nettype none

module rmq_div_cell #(
    parameter int NW  = 31,
    parameter int DVW = 17
) (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire logic [NW-1:0]  i_num,
    input  wire logic [DVW-1:0] i_rem,
    input  wire logic [DVW-1:0] i_den,
    input  wire logic [NW-1:0]  i_quo,
    output logic      [NW-1:0]  o_num,
    output logic      [DVW-1:0] o_rem,
    output logic      [DVW-1:0] o_den,
    output logic      [NW-1:0]  o_quo
);

    logic [DVW:0] w_t;
    logic         w_ge;

    assign w_t  = {i_rem, i_num[NW-1]};
    assign w_ge = (w_t >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_num <= {i_num[NW-2:0], 1'b0};
            o_rem <= w_ge ? DVW'(w_t - {1'b0, i_den}) : DVW'(w_t);
            o_den <= i_den;
            o_quo <= {i_quo[NW-2:0], w_ge};
        end
    end

endmodule

`default_nettype wire

[rtl/rotation_matrix_to_quaternion_core.sv]
// ============================================================================
// rotation_matrix_to_quaternion_core
// Shepperd conversion of a 3x3 rotation matrix to a quaternion, fixed point,
// built as a square root cell chain followed by four division cell chains.
// ============================================================================
//
//  channel | valid   | stall    | payload
//  --------+---------+----------+---------------------------
//  input   | i_valid | o_stall  | i_data (rmq_pkg::t_in)
//  output  | o_valid | i_stall  | o_data (rmq_pkg::t_out)
//
// One item per cycle sustained while the output is not stalled. The path runs
// through the front stage, one sqrt cell per root bit, one divide cell per
// quotient bit and the output register.
// The whole chain advances together whenever the output register is empty or
// taken. While the output stalls, one item is still taken into a skid
// register; o_stall rises only once that is full.
// Reset (synchronous, active low) clears valid bits only.
// ============================================================================
`default_nettype none

module rotation_matrix_to_quaternion_core #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire rmq_pkg::t_in  i_data,
    output logic               o_valid,
    input  wire logic          i_stall,
    output rmq_pkg::t_out      o_data
);

    localparam int W    = rmq_pkg::DATA_W;
    localparam int F    = FRAC_BITS;
    localparam int SW   = ((W > F) ? W : F + 1) + 3;   // candidate sum width
    localparam int XW0  = SW - 1 + F;                  // radicand bits
    localparam int RW   = (XW0 + 1) / 2;               // root bits
    localparam int XW   = 2 * RW;
    localparam int DVW  = RW + 1;                      // divisor 4*v
    localparam int PW   = W + 1;                       // pair magnitude
    localparam int NW   = PW + F;                      // numerator / quotient
    localparam int VW   = RW - 1;

    localparam logic [W-1:0] MAX_Q  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_Q  = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONE_Q  = (F >= W - 1) ? MAX_Q : (W'(1) << F);
    localparam logic signed [SW-1:0] ONE_S = SW'(1) << F;

    // ---------------------------------------------------------------- skid
    logic r_skid_valid;
    rmq_pkg::t_in r_skid;
    logic w_en, w_acc, w_front_valid;
    rmq_pkg::t_in w_m;

    assign w_en          = !(o_valid && i_stall);
    assign o_stall       = r_skid_valid;
    assign w_acc         = i_valid && !r_skid_valid;
    assign w_m           = r_skid_valid ? r_skid : i_data;
    assign w_front_valid = r_skid_valid || w_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (w_en) begin
            r_skid_valid <= 1'b0;
        end else if (w_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_en && w_acc) begin
            r_skid <= i_data;
        end
    end

    // ---------------------------------------------------------- front stage
    logic signed [SW-1:0] w_s [4];
    logic signed [SW-1:0] w_sbest;
    logic [1:0]           w_best;
    logic                 w_degen;
    logic signed [W:0]    w_pa, w_pb, w_pc, w_pd, w_pe, w_pf;
    logic signed [W:0]    w_p [4];

    always_comb begin
        w_s[0] = ONE_S + SW'(w_m.m00) - SW'(w_m.m11) - SW'(w_m.m22);
        w_s[1] = ONE_S - SW'(w_m.m00) + SW'(w_m.m11) - SW'(w_m.m22);
        w_s[2] = ONE_S - SW'(w_m.m00) - SW'(w_m.m11) + SW'(w_m.m22);
        w_s[3] = ONE_S + SW'(w_m.m00) + SW'(w_m.m11) + SW'(w_m.m22);
        w_best  = rmq_pkg::IDX_X;
        w_sbest = w_s[0];
        if (w_s[1] > w_sbest) begin
            w_best  = rmq_pkg::IDX_Y;
            w_sbest = w_s[1];
        end
        if (w_s[2] > w_sbest) begin
            w_best  = rmq_pkg::IDX_Z;
            w_sbest = w_s[2];
        end
        if (w_s[3] > w_sbest) begin
            w_best  = rmq_pkg::IDX_W;
            w_sbest = w_s[3];
        end
        w_degen = (w_sbest <= 0);

        w_pa = (W+1)'(w_m.m01) + (W+1)'(w_m.m10);
        w_pb = (W+1)'(w_m.m20) + (W+1)'(w_m.m02);
        w_pc = (W+1)'(w_m.m12) + (W+1)'(w_m.m21);
        w_pd = (W+1)'(w_m.m12) - (W+1)'(w_m.m21);
        w_pe = (W+1)'(w_m.m20) - (W+1)'(w_m.m02);
        w_pf = (W+1)'(w_m.m01) - (W+1)'(w_m.m10);
        for (int k = 0; k < 4; k++) begin
            w_p[k] = '0;
        end
        unique case (w_best)
            rmq_pkg::IDX_X: begin
                w_p[1] = w_pa; w_p[2] = w_pb; w_p[3] = w_pd;
            end
            rmq_pkg::IDX_Y: begin
                w_p[0] = w_pa; w_p[2] = w_pc; w_p[3] = w_pe;
            end
            rmq_pkg::IDX_Z: begin
                w_p[0] = w_pb; w_p[1] = w_pc; w_p[3] = w_pf;
            end
            default: begin
                w_p[0] = w_pd; w_p[1] = w_pe; w_p[2] = w_pf;
            end
        endcase
    end

    // side info through the sqrt chain: magnitudes, signs, index, flag
    localparam int STW = 4 * PW + 4 + 2 + 1;
    logic [STW-1:0] w_ftag;
    logic [XW-1:0]  w_frad;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_ftag[k*PW +: PW] = w_p[k][W] ? PW'(-w_p[k]) : PW'(w_p[k]);
            w_ftag[4*PW + k]   = w_p[k][W];
        end
        w_ftag[4*PW+4 +: 2] = w_best;
        w_ftag[STW-1]       = w_degen;
        w_frad = w_degen ? '0 : XW'({w_sbest[SW-2:0], {F{1'b0}}});
    end

    // front register is stage 0 of the sqrt chain's valid and tag rows
    logic           r_sv   [RW+1];
    logic [STW-1:0] r_stag [RW+1];
    logic [XW-1:0]  r_frad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (w_en) begin
            r_sv[0] <= w_front_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_stag[0] <= w_ftag;
            r_frad    <= w_frad;
        end
    end

    // ----------------------------------------------------------- sqrt chain
    logic [XW-1:0]  w_rad  [RW+1];
    logic [RW:0]    w_rem  [RW+1];
    logic [RW-1:0]  w_root [RW+1];

    assign w_rad[0]  = r_frad;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    for (genvar g = 0; g < RW; g++) begin : g_sqrt
        rmq_sqrt_cell #(.RW(RW)) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rad  (w_rad[g]),
            .i_rem  (w_rem[g]),
            .i_root (w_root[g]),
            .o_rad  (w_rad[g+1]),
            .o_rem  (w_rem[g+1]),
            .o_root (w_root[g+1])
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[g+1] <= 1'b0;
            end else if (w_en) begin
                r_sv[g+1] <= r_sv[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_stag[g+1] <= r_stag[g];
            end
        end
    end

    // --------------------------------------------------------- divide lanes
    localparam int DTW = VW + 4 + 2 + 1;
    logic [VW-1:0]  w_v;
    logic [DVW-1:0] w_den;
    logic [STW-1:0] w_stag_end;

    assign w_stag_end = r_stag[RW];
    assign w_v        = w_root[RW][RW-1:1];
    assign w_den      = {w_v, 2'b00};

    logic [NW-1:0]  w_num [4][NW+1];
    logic [DVW-1:0] w_drm [4][NW+1];
    logic [DVW-1:0] w_dd  [4][NW+1];
    logic [NW-1:0]  w_quo [4][NW+1];
    logic           w_dv0;
    logic [DTW-1:0] w_dtag0;
    logic           r_dv   [1:NW];
    logic [DTW-1:0] r_dtag [1:NW];

    assign w_dv0   = r_sv[RW];
    assign w_dtag0 = {w_stag_end[STW-1 -: 7], w_v};

    for (genvar ln = 0; ln < 4; ln++) begin : g_lane
        assign w_num[ln][0] = {w_stag_end[ln*PW +: PW], {F{1'b0}}};
        assign w_drm[ln][0] = '0;
        assign w_dd[ln][0]  = w_den;
        assign w_quo[ln][0] = '0;

        for (genvar g = 0; g < NW; g++) begin : g_step
            rmq_div_cell #(.NW(NW), .DVW(DVW)) u_cell (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_num (w_num[ln][g]),
                .i_rem (w_drm[ln][g]),
                .i_den (w_dd[ln][g]),
                .i_quo (w_quo[ln][g]),
                .o_num (w_num[ln][g+1]),
                .o_rem (w_drm[ln][g+1]),
                .o_den (w_dd[ln][g+1]),
                .o_quo (w_quo[ln][g+1])
            );
        end
    end

    for (genvar g = 1; g <= NW; g++) begin : g_dtag
        logic           w_dv_prev;
        logic [DTW-1:0] w_dtag_prev;

        if (g == 1) begin : g_head
            assign w_dv_prev   = w_dv0;
            assign w_dtag_prev = w_dtag0;
        end else begin : g_body
            assign w_dv_prev   = r_dv[g-1];
            assign w_dtag_prev = r_dtag[g-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[g] <= 1'b0;
            end else if (w_en) begin
                r_dv[g] <= w_dv_prev;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dtag[g] <= w_dtag_prev;
            end
        end
    end

    // ------------------------------------------------------ output register
    function automatic logic [W-1:0] sat_q(input logic neg, input logic [NW-1:0] mag);
        logic [NW-1:0] lim;
        lim = neg ? (NW'(1) << (W - 1)) : ((NW'(1) << (W - 1)) - NW'(1));
        if (mag > lim) begin
            sat_q = neg ? MIN_Q : MAX_Q;
        end else begin
            sat_q = neg ? W'(~mag + NW'(1)) : W'(mag);
        end
    endfunction

    logic [DTW-1:0] w_dt;
    logic [1:0]     w_obest;
    logic           w_odegen;
    logic [W-1:0]   w_q [4];

    assign w_dt     = r_dtag[NW];
    assign w_odegen = w_dt[DTW-1];
    assign w_obest  = w_dt[VW+4 +: 2];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (w_odegen) begin
                w_q[k] = (k == 3) ? ONE_Q : '0;
            end else if (w_obest == 2'(k)) begin
                w_q[k] = sat_q(1'b0, NW'(w_dt[VW-1:0]));
            end else begin
                w_q[k] = sat_q(w_dt[VW + k], w_quo[k][NW]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_en) begin
            o_valid <= r_dv[NW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_data.qx            <= w_q[0];
            o_data.qy            <= w_q[1];
            o_data.qz            <= w_q[2];
            o_data.qw            <= w_q[3];
            o_data.largest_index <= w_obest;
            o_data.degenerate    <= w_odegen;
        end
    end

endmodule

`default_nettype wire

[rtl/rmq_checker.sv]
// ============================================================================
// rmq_checker
// Port-level checks of the quaternion core, bound to the top level.
// ============================================================================
`default_nettype none

module rmq_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          o_stall,
    input wire logic          o_valid,
    input wire logic          i_stall,
    input wire rmq_pkg::t_out o_data
);

    localparam int SB = rmq_pkg::DATA_W - 1;

    // degenerate items carry the identity vector part
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.degenerate) |->
        (o_data.qx == 0 && o_data.qy == 0 && o_data.qz == 0))
        else $error("degenerate item with nonzero vector part");

    // the chosen component is a square root, never negative
    a_chosen_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.degenerate) |->
        ((o_data.largest_index == rmq_pkg::IDX_X && !o_data.qx[SB]) ||
         (o_data.largest_index == rmq_pkg::IDX_Y && !o_data.qy[SB]) ||
         (o_data.largest_index == rmq_pkg::IDX_Z && !o_data.qz[SB]) ||
         (o_data.largest_index == rmq_pkg::IDX_W && !o_data.qw[SB])))
        else $error("chosen component negative");

    // input back-pressure only follows a stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> $past(o_valid && i_stall))
        else $error("input stalled without output back-pressure");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!o_valid && !o_stall))
        else $error("pipeline not empty after reset");

endmodule

bind rotation_matrix_to_quaternion_core rmq_checker u_rmq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

`default_nettype wire
